/* rtl/core/dome_mesh_vertex_generator_assert.svh */
// assertion macros for the dome vertex generator
// expects clk and rst in the scope of the including module
`ifndef DOME_MESH_VERTEX_GENERATOR_ASSERT_SVH
`define DOME_MESH_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication
`define DMVG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define DMVG_ASSERT_LAT(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* rtl/core/dmvg_pkg.sv */
// shared types, constants and arithmetic helpers for the dome vertex generator
// no dependencies
`default_nettype none

package dmvg_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int MAX_STEPS         = 1024;

  // long division: quotient bits (one per stage) and divisor width
  localparam int DIV_BITS = 32;
  localparam int DEN_W    = 27;

  localparam int COR_LAT  = CORDIC_ITERATIONS + 2;
  // stage count from the accepting edge to the result strobe
  localparam int OUT_LAT  = 2 * DIV_BITS + COR_LAT + 5;
  // sideband delay from the second stage to the last compute stage
  localparam int SIDE_DLY = 2 * DIV_BITS + COR_LAT + 2;
  // delay of normals and positions while the texcoord divisions finish
  localparam int NP_DLY   = DIV_BITS - 2;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [29:0] ATAN_TAB [24] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_FOV      = 2'd1,
    REG_AZ_STEPS = 2'd2,
    REG_EL_STEPS = 2'd3
  } reg_idx_t;

  // per-word control that rides alongside the arithmetic
  typedef struct packed {
    logic        bad;
    logic        cap;
    logic [10:0] w;
  } side_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [24:0] px;
    logic signed [24:0] py;
    logic signed [24:0] pz;
  } vec_t;

  function automatic logic [10:0] clamp_steps(input logic [10:0] v);
    if (v < 11'd4) return 11'd4;
    else if ({21'b0, v} > 32'(MAX_STEPS)) return 11'(MAX_STEPS);
    else return v;
  endfunction

  // q30 to q1.15, round half up, saturate
  function automatic logic signed [15:0] round_sat16(input logic signed [33:0] v);
    logic signed [34:0] t;
    t = 35'(v) + 35'sd16384;
    t = t >>> 15;
    if (t > 35'sd32767) return 16'sh7fff;
    else if (t < -35'sd32768) return 16'sh8000;
    else return t[15:0];
  endfunction

  // q30 times radius down to 8 fraction bits, round half up, saturate
  function automatic logic signed [24:0] round_sat25(input logic signed [58:0] p);
    logic signed [59:0] t;
    t = 60'(p) + 60'sd536870912;
    t = t >>> 30;
    if (t > 60'sd16777215) return 25'sh0ffffff;
    else if (t < -60'sd16777216) return 25'sh1000000;
    else return t[24:0];
  endfunction

  // texcoord offset around one half, clipped to 0..65535
  function automatic logic [15:0] tex_sat(input logic signed [17:0] q);
    logic signed [18:0] t;
    t = 19'sd32768 + 19'(q);
    if (t < 19'sd0) return 16'h0000;
    else if (t > 19'sd65535) return 16'hffff;
    else return t[15:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dmvg_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on dmvg_pkg; dividend is {hi, lo} with hi below den
`default_nettype none

module dmvg_div (
  input  logic                          clk,
  input  logic [dmvg_pkg::DEN_W-1:0]    hi,
  input  logic [dmvg_pkg::DIV_BITS-1:0] lo,
  input  logic [dmvg_pkg::DEN_W-1:0]    den,
  input  logic                          neg,
  output logic [dmvg_pkg::DIV_BITS-1:0] q
);

  logic [dmvg_pkg::DEN_W-1:0]    rem [dmvg_pkg::DIV_BITS+1];
  logic [dmvg_pkg::DIV_BITS-1:0] sh  [dmvg_pkg::DIV_BITS+1];
  logic                          ng  [dmvg_pkg::DIV_BITS+1];

  assign rem[0] = hi;
  assign sh[0]  = lo;
  assign ng[0]  = neg;

  // each stage brings down one dividend bit and shifts in one quotient bit
  for (genvar k = 0; k < dmvg_pkg::DIV_BITS; k++) begin : g_step
    logic [dmvg_pkg::DEN_W:0] trial;
    logic [dmvg_pkg::DEN_W:0] diff;
    logic                     take;

    assign trial = {rem[k], sh[k][dmvg_pkg::DIV_BITS-1]};
    assign diff  = trial - {1'b0, den};
    assign take  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      rem[k+1] <= take ? diff[dmvg_pkg::DEN_W-1:0] : trial[dmvg_pkg::DEN_W-1:0];
      sh[k+1]  <= {sh[k][dmvg_pkg::DIV_BITS-2:0], take};
      ng[k+1]  <= ng[k];
    end
  end

  // a negative dividend was complemented going in, so complement the floor
  assign q = ng[dmvg_pkg::DIV_BITS] ? ~sh[dmvg_pkg::DIV_BITS] : sh[dmvg_pkg::DIV_BITS];

endmodule

`default_nettype wire

/* rtl/core/dmvg_cordic.sv */
// pipelined rotation-mode cordic, q30 cosine and sine of a binary angle
// depends on dmvg_pkg
`default_nettype none

module dmvg_cordic (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  localparam int N = dmvg_pkg::CORDIC_ITERATIONS;

  logic signed [33:0] xs [N+1];
  logic signed [33:0] ys [N+1];
  logic signed [32:0] zs [N+1];
  logic [1:0]         qd [N+1];

  logic [31:0] rq;
  logic [1:0]  quad;
  logic [31:0] r;

  // fold the angle to within 45 degrees of the nearest quadrant
  assign rq   = phase + 32'h2000_0000;
  assign quad = rq[31:30];
  assign r    = phase - {quad, 30'b0};

  always_ff @(posedge clk) begin
    xs[0] <= dmvg_pkg::GAIN_Q30;
    ys[0] <= 34'sd0;
    zs[0] <= $signed({r[31], r});
    qd[0] <= quad;
  end

  // micro-rotations toward zero residual angle
  for (genvar i = 0; i < N; i++) begin : g_iter
    logic               pos;
    logic signed [32:0] ang;

    assign pos = ~zs[i][32];
    assign ang = $signed({3'b0, dmvg_pkg::ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      if (pos) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ang;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ang;
      end
      qd[i+1] <= qd[i];
    end
  end

  // undo the quadrant fold
  always_ff @(posedge clk) begin
    case (qd[N])
      2'd0: begin
        cos_q <= xs[N][31:0];
        sin_q <= ys[N][31:0];
      end
      2'd1: begin
        cos_q <= -ys[N][31:0];
        sin_q <= xs[N][31:0];
      end
      2'd2: begin
        cos_q <= -xs[N][31:0];
        sin_q <= -ys[N][31:0];
      end
      default: begin
        cos_q <= ys[N][31:0];
        sin_q <= -xs[N][31:0];
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/dmvg_phase.sv */
// elevation and azimuth binary angles by pipelined rounded division
// depends on dmvg_pkg and dmvg_div
`default_nettype none

module dmvg_phase (
  input  logic                       clk,
  input  logic [10:0]                ring,
  input  logic [9:0]                 around,
  input  logic [15:0]                fov,
  input  logic [10:0]                e_n,
  input  logic [10:0]                a_n,
  input  logic [dmvg_pkg::DEN_W-1:0] den_e,
  input  logic [31:0]                half_e,
  input  logic [dmvg_pkg::DEN_W-1:0] den_a,
  output logic [31:0]                ep,
  output logic [31:0]                ap
);

  logic signed [17:0] lift;
  logic signed [29:0] le_full;
  logic signed [27:0] prod_le;
  logic [26:0]        prod_rf;
  logic [9:0]         a2;

  logic signed [28:0]         num;
  logic                       neg_e;
  logic [dmvg_pkg::DEN_W-1:0] hi_e;
  logic [31:0]                lo_e;
  logic [dmvg_pkg::DEN_W-1:0] hi_a;
  logic [31:0]                lo_a;

  // lift in 1/200 degree, then the two products of the ring numerator
  assign lift    = 18'sd18000 - $signed({2'b0, fov});
  assign le_full = lift * $signed({1'b0, e_n});

  always_ff @(posedge clk) begin
    prod_le <= le_full[27:0];
    prod_rf <= ring * fov;
    a2      <= around;
  end

  // elevation: floor((num*2^32 + 36000E) / 72000E)
  assign num   = 29'(prod_le) + $signed({2'b0, prod_rf});
  assign neg_e = num[28];
  assign hi_e  = neg_e ? ~num[26:0] : num[26:0];
  assign lo_e  = neg_e ? ~half_e : half_e;

  // azimuth: floor((a*2^33 + A) / 2A)
  assign hi_a = {16'b0, a2, 1'b0};
  assign lo_a = {21'b0, a_n};

  dmvg_div u_div_e (
    .clk (clk),
    .hi  (hi_e),
    .lo  (lo_e),
    .den (den_e),
    .neg (neg_e),
    .q   (ep)
  );

  dmvg_div u_div_a (
    .clk (clk),
    .hi  (hi_a),
    .lo  (lo_a),
    .den (den_a),
    .neg (1'b0),
    .q   (ap)
  );

endmodule

`default_nettype wire

/* rtl/core/dmvg_post.sv */
// normal, position and texcoord arithmetic after the sine and cosine units
// depends on dmvg_pkg and dmvg_div
`default_nettype none

module dmvg_post (
  input  logic               clk,
  input  logic signed [31:0] ce,
  input  logic signed [31:0] se,
  input  logic signed [31:0] ca,
  input  logic signed [31:0] sa,
  input  logic [10:0]        w,
  input  logic [10:0]        e_n,
  input  logic [23:0]        radius,
  output dmvg_pkg::vec_t     vec,
  output logic signed [17:0] tex_sq,
  output logic signed [17:0] tex_tq
);

  logic signed [63:0] pxs;
  logic signed [63:0] pzc;
  logic signed [43:0] wsa;
  logic signed [43:0] wca;
  logic signed [31:0] se53;

  logic signed [63:0] rx;
  logic signed [63:0] rz;
  logic signed [44:0] ebias;
  logic signed [44:0] ts;
  logic signed [44:0] tt;
  logic signed [28:0] us;
  logic signed [28:0] ut;
  logic [28:0]        ms;
  logic [28:0]        mt;

  logic signed [33:0] n30x;
  logic signed [33:0] n30y;
  logic signed [33:0] n30z;
  logic [dmvg_pkg::DEN_W-1:0] hi_s;
  logic [dmvg_pkg::DEN_W-1:0] hi_t;
  logic [31:0]        lo_s;
  logic [31:0]        lo_t;
  logic               neg_s;
  logic               neg_t;

  logic signed [15:0] nrm_x;
  logic signed [15:0] nrm_y;
  logic signed [15:0] nrm_z;
  logic signed [58:0] pp_x;
  logic signed [58:0] pp_y;
  logic signed [58:0] pp_z;
  logic signed [24:0] rad_s;

  dmvg_pkg::vec_t vec56;
  dmvg_pkg::vec_t vec_pipe [dmvg_pkg::NP_DLY];

  logic [31:0] q_s;
  logic [31:0] q_t;

  // products of the two angle units and the texcoord weight
  always_ff @(posedge clk) begin
    pxs  <= ce * sa;
    pzc  <= ce * ca;
    wsa  <= $signed({1'b0, w}) * sa;
    wca  <= $signed({1'b0, w}) * ca;
    se53 <= se;
  end

  // q30 rounding of the normal, texcoord numerators split by sign
  assign rx    = (pxs + 64'sd536870912) >>> 30;
  assign rz    = (pzc + 64'sd536870912) >>> 30;
  assign ebias = $signed({19'b0, e_n, 15'b0});
  assign ts    = $signed({wsa, 1'b0}) + ebias;
  assign tt    = ebias - $signed({wca, 1'b0});
  assign us    = ts[44:16];
  assign ut    = tt[44:16];
  assign ms    = us[28] ? ~us : us;
  assign mt    = ut[28] ? ~ut : ut;

  always_ff @(posedge clk) begin
    n30x  <= rx[33:0];
    n30y  <= 34'(se53);
    n30z  <= -rz[33:0];
    neg_s <= us[28];
    neg_t <= ut[28];
    hi_s  <= {16'b0, ms[28:18]};
    hi_t  <= {16'b0, mt[28:18]};
    lo_s  <= {ms[17:0], {14{us[28]}}};
    lo_t  <= {mt[17:0], {14{ut[28]}}};
  end

  // normals and raw position products
  assign rad_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    nrm_x <= dmvg_pkg::round_sat16(n30x);
    nrm_y <= dmvg_pkg::round_sat16(n30y);
    nrm_z <= dmvg_pkg::round_sat16(n30z);
    pp_x  <= n30x * rad_s;
    pp_y  <= n30y * rad_s;
    pp_z  <= n30z * rad_s;
  end

  always_ff @(posedge clk) begin
    vec56.nx <= nrm_x;
    vec56.ny <= nrm_y;
    vec56.nz <= nrm_z;
    vec56.px <= dmvg_pkg::round_sat25(pp_x);
    vec56.py <= dmvg_pkg::round_sat25(pp_y);
    vec56.pz <= dmvg_pkg::round_sat25(pp_z);
  end

  // hold the vector while the texcoord divisions run
  always_ff @(posedge clk) begin
    vec_pipe[0] <= vec56;
    for (int k = 1; k < dmvg_pkg::NP_DLY; k++) begin
      vec_pipe[k] <= vec_pipe[k-1];
    end
  end

  assign vec = vec_pipe[dmvg_pkg::NP_DLY-1];

  // divide by E with 14 extra fraction bits, drop them after
  dmvg_div u_div_s (
    .clk (clk),
    .hi  (hi_s),
    .lo  (lo_s),
    .den ({16'b0, e_n}),
    .neg (neg_s),
    .q   (q_s)
  );

  dmvg_div u_div_t (
    .clk (clk),
    .hi  (hi_t),
    .lo  (lo_t),
    .den ({16'b0, e_n}),
    .neg (neg_t),
    .q   (q_t)
  );

  assign tex_sq = $signed(q_s[31:14]);
  assign tex_tq = $signed(q_t[31:14]);

endmodule

`default_nettype wire

/* rtl/core/dome_mesh_vertex_generator.sv */
// dome vertex generator: one word in per cycle, with one registered result strobe per accepted word
// pipeline depth comes mostly from two 32-stage dividers in series around an 18-stage cordic
// throughput one vertex per clock; busy is high only during reset
// sync reset clears config to radius 256, fov 18000, 4 by 4 steps, and all valid bits
// the receiver cannot stall; every accepted word gives exactly one strobe
`default_nettype none

module dome_mesh_vertex_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [10:0]        ring,
  input  logic [9:0]         around,
  output logic               done,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic signed [24:0] pos_x,
  output logic signed [24:0] pos_y,
  output logic signed [24:0] pos_z,
  output logic [15:0]        tex_s,
  output logic [15:0]        tex_t,
  output logic               bad_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [23:0] radius;
  logic [15:0] field_of_view;
  logic [10:0] azimuth_steps;
  logic [10:0] elevation_steps;

  logic [10:0]                e_c;
  logic [10:0]                a_c;
  logic [dmvg_pkg::DEN_W-1:0] den_e;
  logic [31:0]                half_e;
  logic [dmvg_pkg::DEN_W-1:0] den_a;

  logic        v1;
  logic [10:0] ring1;
  logic [9:0]  around1;

  dmvg_pkg::side_t side_next;
  dmvg_pkg::side_t side2;
  logic            v2;
  dmvg_pkg::side_t spipe [dmvg_pkg::SIDE_DLY];
  logic            vpipe [dmvg_pkg::SIDE_DLY];
  dmvg_pkg::side_t side_end;

  logic [31:0]        ep;
  logic [31:0]        ap;
  logic signed [31:0] ce;
  logic signed [31:0] se;
  logic signed [31:0] ca;
  logic signed [31:0] sa;

  dmvg_pkg::vec_t     vec;
  logic signed [17:0] tex_sq;
  logic signed [17:0] tex_tq;

  logic cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius          <= 24'd256;
      field_of_view   <= 16'd18000;
      azimuth_steps   <= 11'd4;
      elevation_steps <= 11'd4;
    end else if (cfg_wr) begin
      unique case (dmvg_pkg::reg_idx_t'(paddr[3:2]))
        dmvg_pkg::REG_RADIUS:   radius          <= pwdata[23:0];
        dmvg_pkg::REG_FOV:      field_of_view   <= pwdata[15:0];
        dmvg_pkg::REG_AZ_STEPS: azimuth_steps   <= pwdata[10:0];
        dmvg_pkg::REG_EL_STEPS: elevation_steps <= pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (dmvg_pkg::reg_idx_t'(paddr[3:2]))
      dmvg_pkg::REG_RADIUS:   prdata = {8'b0, radius};
      dmvg_pkg::REG_FOV:      prdata = {16'b0, field_of_view};
      dmvg_pkg::REG_AZ_STEPS: prdata = {21'b0, azimuth_steps};
      dmvg_pkg::REG_EL_STEPS: prdata = {21'b0, elevation_steps};
    endcase
  end

  // clamped step counts and divisors, refreshed every cycle
  always_ff @(posedge clk) begin
    e_c    <= dmvg_pkg::clamp_steps(elevation_steps);
    a_c    <= dmvg_pkg::clamp_steps(azimuth_steps);
    den_e  <= 27'({10'b0, 17'd72000} * {16'b0, e_c});
    half_e <= 32'({15'b0, 17'd36000} * {21'b0, e_c});
    den_a  <= {15'b0, a_c, 1'b0};
  end

  // input register
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    ring1   <= ring;
    around1 <= around;
  end

  // index checks
  always_comb begin
    side_next.bad = (ring1 > e_c) || ((ring1 < e_c) && ({1'b0, around1} >= a_c));
    side_next.cap = (ring1 == e_c);
    side_next.w   = e_c - ring1;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    side2 <= side_next;
  end

  // valid bits and sideband alongside the arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < dmvg_pkg::SIDE_DLY; k++) vpipe[k] <= 1'b0;
    end else begin
      vpipe[0] <= v2;
      for (int k = 1; k < dmvg_pkg::SIDE_DLY; k++) vpipe[k] <= vpipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    spipe[0] <= side2;
    for (int k = 1; k < dmvg_pkg::SIDE_DLY; k++) spipe[k] <= spipe[k-1];
  end

  assign side_end = spipe[dmvg_pkg::SIDE_DLY-1];

  // angles
  dmvg_phase u_phase (
    .clk    (clk),
    .ring   (ring1),
    .around (around1),
    .fov    (field_of_view),
    .e_n    (e_c),
    .a_n    (a_c),
    .den_e  (den_e),
    .half_e (half_e),
    .den_a  (den_a),
    .ep     (ep),
    .ap     (ap)
  );

  dmvg_cordic u_cordic_e (
    .clk   (clk),
    .phase (ep),
    .cos_q (ce),
    .sin_q (se)
  );

  dmvg_cordic u_cordic_a (
    .clk   (clk),
    .phase (ap),
    .cos_q (ca),
    .sin_q (sa)
  );

  dmvg_post u_post (
    .clk    (clk),
    .ce     (ce),
    .se     (se),
    .ca     (ca),
    .sa     (sa),
    .w      (spipe[dmvg_pkg::DIV_BITS+dmvg_pkg::COR_LAT-1].w),
    .e_n    (e_c),
    .radius (radius),
    .vec    (vec),
    .tex_sq (tex_sq),
    .tex_tq (tex_tq)
  );

  // result register with the bad index and cap overrides
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vpipe[dmvg_pkg::SIDE_DLY-1];
  end

  always_ff @(posedge clk) begin
    if (side_end.bad) begin
      normal_x  <= 16'sd0;
      normal_y  <= 16'sd0;
      normal_z  <= 16'sd0;
      pos_x     <= 25'sd0;
      pos_y     <= 25'sd0;
      pos_z     <= 25'sd0;
      tex_s     <= 16'd0;
      tex_t     <= 16'd0;
      bad_index <= 1'b1;
    end else if (side_end.cap) begin
      normal_x  <= 16'sd0;
      normal_y  <= 16'sd32767;
      normal_z  <= 16'sd0;
      pos_x     <= 25'sd0;
      pos_y     <= $signed({1'b0, radius});
      pos_z     <= 25'sd0;
      tex_s     <= 16'd32768;
      tex_t     <= 16'd32768;
      bad_index <= 1'b0;
    end else begin
      normal_x  <= vec.nx;
      normal_y  <= vec.ny;
      normal_z  <= vec.nz;
      pos_x     <= vec.px;
      pos_y     <= vec.py;
      pos_z     <= vec.pz;
      tex_s     <= dmvg_pkg::tex_sat(tex_sq);
      tex_t     <= dmvg_pkg::tex_sat(tex_tq);
      bad_index <= 1'b0;
    end
  end

`include "dome_mesh_vertex_generator_assert.svh"

  // every accepted word comes out after the fixed pipeline depth
`DMVG_ASSERT_LAT(a_latency, start && !busy, (dmvg_pkg::OUT_LAT), done, "missing result strobe")
  // a flagged word carries no geometry
`DMVG_ASSERT_NOW(a_bad_zero, done && bad_index, normal_x == 16'sd0 && normal_y == 16'sd0 && pos_y == 25'sd0 && tex_s == 16'd0 && tex_t == 16'd0, "bad index word not cleared")

endmodule

`default_nettype wire

/* tb/dmvg_checker.sv */
// checker for the dome vertex generator: follows register writes, predicts each vertex
// and compares every result strobe against the oldest pending prediction; needs dmvg_pkg
`default_nettype none

module dmvg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [10:0]        ring,
  input  logic [9:0]         around,
  input  logic               done,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [24:0] pos_x,
  input  logic signed [24:0] pos_y,
  input  logic signed [24:0] pos_z,
  input  logic [15:0]        tex_s,
  input  logic [15:0]        tex_t,
  input  logic               bad_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  localparam int ROT_STEPS = dmvg_pkg::CORDIC_ITERATIONS;
  localparam longint START_X = 64'sd652032874;
  localparam longint Q30 = 64'sd1073741824;

  localparam longint ARCTAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    longint nx, ny, nz, px, py, pz, s, t, bad;
  } vertex_t;

  vertex_t vertex_q[$];
  logic [23:0] radius_r;
  logic [15:0] fov_r;
  logic [10:0] az_steps_r;
  logic [10:0] el_steps_r;

  // round half up
  function automatic longint div_round(longint n, longint d);
    longint t, dd;
    t = 2 * n + d;
    dd = 2 * d;
    if (t >= 0) return t / dd;
    return -((-t + dd - 1) / dd);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint steps_used(logic [10:0] v);
    if (v < 4) return 4;
    if (v > dmvg_pkg::MAX_STEPS) return dmvg_pkg::MAX_STEPS;
    return longint'(v);
  endfunction

  // quadrant fold, then fixed-count rotation toward zero angle
  function automatic void rotate_phase(input logic [31:0] ph, output longint c,
                                       output longint s);
    logic [31:0] q, rr;
    longint z, x, y, nx;
    q = ((ph + 32'h2000_0000) >> 30) & 32'd3;
    rr = ph - (q << 30);
    z = rr >= 32'h8000_0000 ? longint'({32'b0, rr}) - 64'sd4294967296
                            : longint'({32'b0, rr});
    x = START_X;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic vertex_t predict_vertex(logic [10:0] rg, logic [9:0] az);
    vertex_t v;
    longint e_n, a_n, r, a, rad, lift, num, ep, ap, ce, se, ca, sa, w;
    longint n3 [3];
    v = '{default: 0};
    e_n = steps_used(el_steps_r);
    a_n = steps_used(az_steps_r);
    r = longint'(rg);
    a = longint'(az);
    rad = longint'(radius_r);
    if (r > e_n || (r < e_n && a >= a_n)) begin
      v.bad = 1;
    end else if (r == e_n) begin
      v.ny = 32767;
      v.py = rad;
      v.s = 32768;
      v.t = 32768;
    end else begin
      lift = 18000 - longint'(fov_r);
      num = lift * e_n + r * (18000 - lift);
      ep = div_round(num * 64'sd4294967296, 72000 * e_n);
      ap = div_round(a * 64'sd4294967296, a_n);
      rotate_phase(ep[31:0], ce, se);
      rotate_phase(ap[31:0], ca, sa);
      w = e_n - r;
      n3[0] = div_round(ce * sa, Q30);
      n3[1] = se;
      n3[2] = -div_round(ce * ca, Q30);
      v.nx = clip(div_round(n3[0], 32768), -32768, 32767);
      v.ny = clip(div_round(n3[1], 32768), -32768, 32767);
      v.nz = clip(div_round(n3[2], 32768), -32768, 32767);
      v.px = clip(div_round(n3[0] * rad, Q30), -16777216, 16777215);
      v.py = clip(div_round(n3[1] * rad, Q30), -16777216, 16777215);
      v.pz = clip(div_round(n3[2] * rad, Q30), -16777216, 16777215);
      v.s = clip(32768 + div_round(w * sa, e_n * 32768), 0, 65535);
      v.t = clip(32768 + div_round(-(w * ca), e_n * 32768), 0, 65535);
    end
    return v;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  assign pending = vertex_q.size();

  // register shadow, predictions and result checks
  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      vertex_q.delete();
      radius_r <= 24'd256;
      fov_r <= 16'd18000;
      az_steps_r <= 11'd4;
      el_steps_r <= 11'd4;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (dmvg_pkg::reg_idx_t'(paddr[3:2]))
          dmvg_pkg::REG_RADIUS:   radius_r <= pwdata[23:0];
          dmvg_pkg::REG_FOV:      fov_r <= pwdata[15:0];
          dmvg_pkg::REG_AZ_STEPS: az_steps_r <= pwdata[10:0];
          dmvg_pkg::REG_EL_STEPS: el_steps_r <= pwdata[10:0];
          default: ;
        endcase
      end
      if (start && !busy) vertex_q = {vertex_q, predict_vertex(ring, around)};
      if (done) begin
        if (vertex_q.size() == 0) begin
          $error("result word with no request outstanding");
          errors++;
        end else begin
          want = vertex_q.pop_front();
          checked++;
          compare_field("normal_x", want.nx, longint'(normal_x));
          compare_field("normal_y", want.ny, longint'(normal_y));
          compare_field("normal_z", want.nz, longint'(normal_z));
          compare_field("pos_x", want.px, longint'(pos_x));
          compare_field("pos_y", want.py, longint'(pos_y));
          compare_field("pos_z", want.pz, longint'(pos_z));
          compare_field("tex_s", want.s, longint'(tex_s));
          compare_field("tex_t", want.t, longint'(tex_t));
          compare_field("bad_index", want.bad, longint'(bad_index));
        end
      end
    end
  end

  initial begin
    errors = 0;
    checked = 0;
  end

endmodule

`default_nettype wire

/* tb/tb_dome_mesh_vertex_generator.sv */
// top of the dome vertex generator testbench: clock, reset, register phases and requests
// depends on dmvg_pkg, dome_mesh_vertex_generator and dmvg_checker
`default_nettype none

module tb_dome_mesh_vertex_generator;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES = 9;
  localparam int WORDS_PER_PHASE = 85;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [10:0] ring = '0;
  logic [9:0] around = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy, done, bad_index, pready;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic signed [24:0] pos_x, pos_y, pos_z;
  logic [15:0] tex_s, tex_t;
  logic [31:0] prdata;
  int errors, pending, checked;
  int cycles = 0;
  int idle_pct = 0;
  int phases_run = 0;
  longint el_n = 4, az_n = 4;

  dome_mesh_vertex_generator i_dut (.*);

  dmvg_checker i_checker (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint steps_used(longint v);
    return v < 4 ? 4 : (v > dmvg_pkg::MAX_STEPS ? dmvg_pkg::MAX_STEPS : v);
  endfunction

  task automatic reg_write(dmvg_pkg::reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == dmvg_pkg::REG_AZ_STEPS) az_n = steps_used(longint'(val[10:0]));
    if (idx == dmvg_pkg::REG_EL_STEPS) el_n = steps_used(longint'(val[10:0]));
  endtask

  // one request word; start stays high unless a gap follows
  task automatic send_vertex(logic [10:0] rg, logic [9:0] az);
    bit taken;
    start <= 1'b1;
    ring <= rg;
    around <= az;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly well-formed vertices, some out-of-range noise
  task automatic random_vertex;
    longint rg;
    if ($urandom_range(0, 99) < 85) begin
      rg = $urandom_range(0, el_n);
      if (rg == el_n) send_vertex(11'(rg), 10'($urandom_range(0, 1023)));
      else send_vertex(11'(rg), 10'($urandom_range(0, az_n - 1)));
    end else begin
      send_vertex(11'($urandom_range(0, 2047)), 10'($urandom_range(0, 1023)));
    end
  endtask

  task automatic set_phase(int p);
    case (p)
      1: begin
        reg_write(dmvg_pkg::REG_RADIUS, 32'd0);
        reg_write(dmvg_pkg::REG_FOV, 32'd1);
      end
      2: begin
        reg_write(dmvg_pkg::REG_RADIUS, 32'hff_ffff);
        reg_write(dmvg_pkg::REG_FOV, 32'd36000);
        reg_write(dmvg_pkg::REG_AZ_STEPS, 32'd1024);
        reg_write(dmvg_pkg::REG_EL_STEPS, 32'd1024);
      end
      3: begin
        reg_write(dmvg_pkg::REG_FOV, 32'd0);
        reg_write(dmvg_pkg::REG_AZ_STEPS, 32'd3);
        reg_write(dmvg_pkg::REG_EL_STEPS, 32'd2047);
      end
      4: begin
        reg_write(dmvg_pkg::REG_RADIUS, 32'd1234567);
        reg_write(dmvg_pkg::REG_FOV, 32'd65535);
        reg_write(dmvg_pkg::REG_AZ_STEPS, 32'd2047);
        reg_write(dmvg_pkg::REG_EL_STEPS, 32'd0);
      end
      5: begin
        reg_write(dmvg_pkg::REG_RADIUS, 32'd25600);
        reg_write(dmvg_pkg::REG_FOV, 32'd27000);
        reg_write(dmvg_pkg::REG_AZ_STEPS, 32'd17);
        reg_write(dmvg_pkg::REG_EL_STEPS, 32'd9);
      end
      6: begin
        reg_write(dmvg_pkg::REG_RADIUS, 32'(24'($urandom)));
        reg_write(dmvg_pkg::REG_FOV, 32'($urandom_range(1, 36000)));
        reg_write(dmvg_pkg::REG_AZ_STEPS, 32'($urandom_range(4, 64)));
        reg_write(dmvg_pkg::REG_EL_STEPS, 32'($urandom_range(4, 64)));
      end
      7: begin
        reg_write(dmvg_pkg::REG_RADIUS, 32'd256);
        reg_write(dmvg_pkg::REG_FOV, 32'd18000);
        reg_write(dmvg_pkg::REG_AZ_STEPS, 32'd1024);
        reg_write(dmvg_pkg::REG_EL_STEPS, 32'd4);
      end
      default: begin
        reg_write(dmvg_pkg::REG_RADIUS, 32'h80_0000);
        reg_write(dmvg_pkg::REG_FOV, 32'd40000);
        reg_write(dmvg_pkg::REG_AZ_STEPS, 32'd4);
        reg_write(dmvg_pkg::REG_EL_STEPS, 32'd1);
      end
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset settings: base ring, cap, bad indices, field extremes
    idle_pct = 19;
    for (int a = 0; a < 4; a++) send_vertex(11'd0, 10'(a));
    send_vertex(11'd1, 10'd1);
    send_vertex(11'd3, 10'd3);
    send_vertex(11'd4, 10'd0);
    send_vertex(11'd4, 10'd1023);
    send_vertex(11'd5, 10'd0);
    send_vertex(11'd2047, 10'd1023);
    send_vertex(11'd0, 10'd4);
    send_vertex(11'd2, 10'd1023);
    send_vertex(11'd1024, 10'd0);
    send_vertex(11'd3, 10'd2);
    // hold off until every outstanding vertex has returned
    drain;
    send_vertex(11'd2, 10'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      idle_pct = p < 3 ? 19 : (p < 6 ? 67 : 0);
      if (p != 0) begin
        drain;
        set_phase(p);
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) random_vertex();
      phases_run++;
    end
    drain;
    repeat (dmvg_pkg::OUT_LAT + 10) @(posedge clk);

    $display("checked %0d vertex results across %0d register settings", checked,
             phases_run);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
